FILE: hdl/pid_antiwindup_controller_top_macros.svh
// Assertion macros for the PID controller with anti-windup.
// Used by the arithmetic units and the top level; needs clk_i and rst_ni in scope.
`ifndef PID_ANTIWINDUP_CONTROLLER_TOP_MACROS_SVH
`define PID_ANTIWINDUP_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH

`define PIDAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PIDAW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define PIDAW_ASSERT(lbl, prop, msg)

`define PIDAW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: hdl/pidaw_pkg.sv
// Shared widths, codes, unit request/response types and helpers of the PID controller.
// No dependencies; every other file of the block but the assertion macro header refers to it by scoped names.
`default_nettype none

package pidaw_pkg;

  localparam int DATA_W      = 16;
  localparam int DRIVE_W     = 14;
  localparam int ERR_W       = DATA_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int GAIN_FRAC_W = 8;
  localparam int I_SHIFT     = 24;
  localparam int Q_ONE       = 4096;

  localparam int MUL_A_W   = 31;
  localparam int MUL_B_W   = DATA_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int DIV_N_W   = MUL_A_W + GAIN_FRAC_W;
  localparam int DIV_D_W   = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int P_MAG_W = MUL_A_W - GAIN_FRAC_W;
  localparam int I_MAG_W = MUL_P_W - I_SHIFT;
  localparam int TERM_W  = DIV_N_W + 2;
  localparam int ACC_W   = I_MAG_W + 2;
  localparam int SUM_W   = ACC_W + 1;

  localparam logic [DATA_W-1:0] TIME_STEP_RESET = DATA_W'(656);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_TIME_STEP  = 3'd3,
    REG_SETPOINT   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_D,
    S_MUL_P,
    S_MUL_I1,
    S_MUL_I2,
    S_TERM,
    S_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_N_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] mag_err(input logic signed [ERR_W-1:0] v);
    logic [ERR_W-1:0] n;
    n = v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
    return n[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mag_gain(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] n;
    n = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pidaw_if.sv
// Handshake channels of the PID controller: sample input, drive output, register writes.
// Depends on pidaw_pkg for the field widths.
`default_nettype none

interface pidaw_sample_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [pidaw_pkg::DATA_W-1:0] measurement;

  modport source (output valid, operation, measurement, input ready);
  modport sink (input valid, operation, measurement, output ready);
endinterface

interface pidaw_drive_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pidaw_pkg::DRIVE_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

interface pidaw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pidaw_pkg::CFG_IDX_W-1:0] index;
  logic [pidaw_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/pidaw_smul.sv
// Shift-and-add multiplier that retires one bit of the second operand per cycle.
// Depends on pidaw_pkg and the assertion macro header.
`default_nettype none
`include "pid_antiwindup_controller_top_macros.svh"

module pidaw_smul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidaw_pkg::mul_req_t req_i,
  output pidaw_pkg::mul_rsp_t rsp_o
);

  localparam int AW = pidaw_pkg::MUL_A_W;
  localparam int BW = pidaw_pkg::MUL_B_W;
  localparam int CW = pidaw_pkg::MUL_CNT_W;
  localparam logic [CW-1:0] LAST = CW'(BW - 1);

  logic [AW-1:0] a_q, a_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [BW-1:0] lo_q, lo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [AW:0]   sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      hi_d   = '0;
      lo_d   = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[AW:1];
      lo_d  = {sum[0], lo_q[BW-1:1]};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q, lo_q};

  `PIDAW_ASSERT(a_smul_no_restart, req_i.start |-> !busy_q, "multiplier restarted while busy")
  `PIDAW_ASSERT(a_smul_done_after_busy, done_q |-> $past(busy_q), "product flagged without a run")

endmodule

`default_nettype wire

FILE: hdl/pidaw_sdiv.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on pidaw_pkg and the assertion macro header.
`default_nettype none
`include "pid_antiwindup_controller_top_macros.svh"

module pidaw_sdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidaw_pkg::div_req_t req_i,
  output pidaw_pkg::div_rsp_t rsp_o
);

  localparam int NW = pidaw_pkg::DIV_N_W;
  localparam int DW = pidaw_pkg::DIV_D_W;
  localparam int CW = pidaw_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      num_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], fits};
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = num_q;

  `PIDAW_ASSERT(a_sdiv_no_restart, req_i.start |-> !busy_q, "divider restarted while busy")
  `PIDAW_ASSERT(a_sdiv_rem_bound, busy_q |-> (rem_q < den_q), "partial remainder not below divisor")

endmodule

`default_nettype wire

FILE: hdl/pid_antiwindup_controller_top.sv
// PID controller with derivative on measurement and integrator anti-windup.
// Depends on pidaw_pkg, pidaw_if, pidaw_smul, pidaw_sdiv and the assertion macro header.
//
// The sample channel carries one word per control step: an operation bit and a Q4.12
// measurement. A sample word yields one Q2.12 drive word on the drive channel; a clear
// word zeroes the integrator in its accept cycle and yields nothing.
// Gains, time step and setpoint are written through the register channel, which is
// always ready and is meant to be used only while no sample is in flight.
// A sample runs the bit-serial multiplier four times, for the derivative, proportional
// and two integral products, then passes S_TERM for the clipped term and S_OUT for
// the integrator clamp. The divider for the derivative runs beside the last three
// multiplies. The next word is accepted only after S_OUT has registered the drive word.
// The drive word sits in an output register, so a new sample is accepted while an
// earlier drive word still waits; a stalled receiver only holds the block in its last
// cycle of a sample until the waiting word is taken.
// Reset clears the integrator, the last measurement and the gains and setpoint, and
// sets the time step to 656.
`default_nettype none
`include "pid_antiwindup_controller_top_macros.svh"

module pid_antiwindup_controller_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  pidaw_cfg_if.sink      cfg_i,
  pidaw_sample_if.sink   sample_i,
  pidaw_drive_if.source  drive_o
);

  localparam int DW  = pidaw_pkg::DATA_W;
  localparam int EW  = pidaw_pkg::ERR_W;
  localparam int OW  = pidaw_pkg::DRIVE_W;
  localparam int AW  = pidaw_pkg::MUL_A_W;
  localparam int PW  = pidaw_pkg::P_MAG_W;
  localparam int IW  = pidaw_pkg::I_MAG_W;
  localparam int TW  = pidaw_pkg::TERM_W;
  localparam int CW  = pidaw_pkg::ACC_W;
  localparam int SW  = pidaw_pkg::SUM_W;
  localparam int NW  = pidaw_pkg::DIV_N_W;
  localparam int FW  = pidaw_pkg::GAIN_FRAC_W;

  localparam logic signed [TW-1:0] TERM_MAX  = TW'(pidaw_pkg::Q_ONE);
  localparam logic signed [TW-1:0] TERM_MIN  = TW'(-pidaw_pkg::Q_ONE);
  localparam logic signed [SW-1:0] SUM_MAX   = SW'(pidaw_pkg::Q_ONE);
  localparam logic signed [SW-1:0] SUM_MIN   = SW'(-pidaw_pkg::Q_ONE);
  localparam logic signed [OW-1:0] DRIVE_MAX = OW'(pidaw_pkg::Q_ONE);
  localparam logic signed [OW-1:0] DRIVE_MIN = OW'(-pidaw_pkg::Q_ONE);
  localparam logic signed [DW-1:0] INTEG_MAX = DW'(2 * pidaw_pkg::Q_ONE);
  localparam logic signed [DW-1:0] INTEG_MIN = DW'(-2 * pidaw_pkg::Q_ONE);

  pidaw_pkg::state_e state_q, state_d;

  logic signed [DW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q, setpoint_q;
  logic        [DW-1:0] time_step_q;
  logic signed [DW-1:0] integ_q, integ_d;
  logic signed [DW-1:0] prev_q;
  logic signed [DW-1:0] meas_q;
  logic        [DW-1:0] err_mag_q;
  logic                 p_neg_q, i_neg_q, d_neg_q;
  logic        [PW-1:0] p_mag_q;
  logic        [IW-1:0] i_mag_q;
  logic signed [OW-1:0] term_q, term_d;
  logic signed [CW-1:0] acc_q, acc_d;
  logic signed [OW-1:0] drive_q, drive_d;
  logic                 out_valid_q;

  logic        [DW-1:0] dt_eff;
  logic signed [EW-1:0] err_in, dx_in;
  logic                 in_fire;

  logic                 in_ready;
  logic                 ld_in, ld_p, ld_i, ld_term, ld_out, clr_integ;

  pidaw_pkg::mul_req_t  mul_req;
  pidaw_pkg::mul_rsp_t  mul_rsp;
  pidaw_pkg::div_req_t  div_req;
  pidaw_pkg::div_rsp_t  div_rsp;

  logic signed [TW-1:0] p_s, d_s, diff;
  logic signed [CW-1:0] i_s;
  logic signed [SW-1:0] sum;

  pidaw_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  pidaw_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign dt_eff  = (time_step_q == '0) ? DW'(1) : time_step_q;
  assign err_in  = EW'(setpoint_q) - EW'(sample_i.measurement);
  assign dx_in   = EW'(sample_i.measurement) - EW'(prev_q);
  assign in_fire = sample_i.valid && in_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pidaw_pkg::S_IDLE: begin
        if (in_fire && (sample_i.operation == pidaw_pkg::OP_SAMPLE)) begin
          state_d = pidaw_pkg::S_MUL_D;
        end
      end
      pidaw_pkg::S_MUL_D: begin
        if (mul_rsp.done) begin
          state_d = pidaw_pkg::S_MUL_P;
        end
      end
      pidaw_pkg::S_MUL_P: begin
        if (mul_rsp.done) begin
          state_d = pidaw_pkg::S_MUL_I1;
        end
      end
      pidaw_pkg::S_MUL_I1: begin
        if (mul_rsp.done) begin
          state_d = pidaw_pkg::S_MUL_I2;
        end
      end
      pidaw_pkg::S_MUL_I2: begin
        if (mul_rsp.done) begin
          state_d = pidaw_pkg::S_TERM;
        end
      end
      pidaw_pkg::S_TERM: begin
        if (!div_rsp.busy) begin
          state_d = pidaw_pkg::S_OUT;
        end
      end
      pidaw_pkg::S_OUT: begin
        if (!out_valid_q || drive_o.ready) begin
          state_d = pidaw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pidaw_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    ld_in             = 1'b0;
    ld_p              = 1'b0;
    ld_i              = 1'b0;
    ld_term           = 1'b0;
    ld_out            = 1'b0;
    clr_integ         = 1'b0;
    mul_req.start     = 1'b0;
    mul_req.a         = '0;
    mul_req.b         = '0;
    div_req.start     = 1'b0;
    div_req.dividend  = {mul_rsp.prod[AW-1:0], FW'(0)};
    div_req.divisor   = dt_eff;
    case (state_q)
      pidaw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && (sample_i.operation == pidaw_pkg::OP_SAMPLE)) begin
          ld_in         = 1'b1;
          mul_req.start = 1'b1;
          mul_req.a     = AW'(pidaw_pkg::mag_gain(gain_deriv_q));
          mul_req.b     = pidaw_pkg::mag_err(dx_in);
        end
        if (in_fire && (sample_i.operation == pidaw_pkg::OP_CLEAR)) begin
          clr_integ = 1'b1;
        end
      end
      pidaw_pkg::S_MUL_D: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          mul_req.start = 1'b1;
          mul_req.a     = AW'(pidaw_pkg::mag_gain(gain_prop_q));
          mul_req.b     = err_mag_q;
        end
      end
      pidaw_pkg::S_MUL_P: begin
        if (mul_rsp.done) begin
          ld_p          = 1'b1;
          mul_req.start = 1'b1;
          mul_req.a     = AW'(pidaw_pkg::mag_gain(gain_integ_q));
          mul_req.b     = err_mag_q;
        end
      end
      pidaw_pkg::S_MUL_I1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.prod[AW-1:0];
          mul_req.b     = dt_eff;
        end
      end
      pidaw_pkg::S_MUL_I2: begin
        ld_i = mul_rsp.done;
      end
      pidaw_pkg::S_TERM: begin
        ld_term = !div_rsp.busy;
      end
      pidaw_pkg::S_OUT: begin
        ld_out = !out_valid_q || drive_o.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    p_s = signed'({{(TW - PW){1'b0}}, p_mag_q});
    if (p_neg_q) begin
      p_s = -p_s;
    end
    d_s = signed'({{(TW - NW){1'b0}}, div_rsp.quot});
    if (d_neg_q) begin
      d_s = -d_s;
    end
    diff = p_s - d_s;
    if (diff > TERM_MAX) begin
      term_d = DRIVE_MAX;
    end else if (diff < TERM_MIN) begin
      term_d = DRIVE_MIN;
    end else begin
      term_d = diff[OW-1:0];
    end
    i_s = signed'({{(CW - IW){1'b0}}, i_mag_q});
    if (i_neg_q) begin
      i_s = -i_s;
    end
    acc_d = CW'(integ_q) + i_s;
  end

  always_comb begin
    sum = SW'(term_q) + SW'(acc_q);
    if (sum > SUM_MAX) begin
      drive_d = DRIVE_MAX;
    end else if (sum < SUM_MIN) begin
      drive_d = DRIVE_MIN;
    end else begin
      drive_d = sum[OW-1:0];
    end
    integ_d = DW'(drive_d) - DW'(term_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pidaw_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      integ_q      <= '0;
      prev_q       <= '0;
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      time_step_q  <= pidaw_pkg::TIME_STEP_RESET;
      setpoint_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (drive_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (clr_integ) begin
        integ_q <= '0;
      end else if (ld_out) begin
        integ_q <= integ_d;
      end
      if (ld_out) begin
        prev_q <= meas_q;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          pidaw_pkg::REG_GAIN_PROP:  gain_prop_q  <= signed'(cfg_i.data);
          pidaw_pkg::REG_GAIN_INTEG: gain_integ_q <= signed'(cfg_i.data);
          pidaw_pkg::REG_GAIN_DERIV: gain_deriv_q <= signed'(cfg_i.data);
          pidaw_pkg::REG_TIME_STEP:  time_step_q  <= cfg_i.data;
          pidaw_pkg::REG_SETPOINT:   setpoint_q   <= signed'(cfg_i.data);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      meas_q    <= sample_i.measurement;
      err_mag_q <= pidaw_pkg::mag_err(err_in);
      p_neg_q   <= gain_prop_q[DW-1] ^ err_in[EW-1];
      i_neg_q   <= gain_integ_q[DW-1] ^ err_in[EW-1];
      d_neg_q   <= gain_deriv_q[DW-1] ^ dx_in[EW-1];
    end
    if (ld_p) begin
      p_mag_q <= mul_rsp.prod[AW-1:FW];
    end
    if (ld_i) begin
      i_mag_q <= mul_rsp.prod[pidaw_pkg::MUL_P_W-1:pidaw_pkg::I_SHIFT];
    end
    if (ld_term) begin
      term_q <= term_d;
      acc_q  <= acc_d;
    end
    if (ld_out) begin
      drive_q <= drive_d;
    end
  end

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = in_ready;
  assign drive_o.valid  = out_valid_q;
  assign drive_o.drive  = drive_q;

  `PIDAW_ASSERT(a_top_integ, (integ_q <= INTEG_MAX) && (integ_q >= INTEG_MIN), "integ out of range")
  `PIDAW_ASSERT(a_top_drive, out_valid_q |-> (drive_q <= DRIVE_MAX) && (drive_q >= DRIVE_MIN), "bad drive")

endmodule

`default_nettype wire

FILE: tb/tb_pid_antiwindup_controller_top.sv
// Self-checking testbench for pid_antiwindup_controller_top: drives register writes and sample
// words, predicts every drive word in a scoreboard class and checks it in order.
// Depends on pidaw_pkg, the pidaw_if interfaces and the controller RTL.
`timescale 1ns / 1ps

module tb_pid_antiwindup_controller_top;

  localparam int  SETTLE_CYCLES = 80;
  localparam int  CYCLE_LIMIT   = 1500000;
  localparam int  RAND_GROUPS   = 18;
  localparam int  GROUP_WORDS   = 103;
  localparam int  DW            = pidaw_pkg::DATA_W;
  localparam int  OW            = pidaw_pkg::DRIVE_W;
  localparam int  XW            = pidaw_pkg::CFG_IDX_W;
  localparam longint Q_ONE      = longint'(pidaw_pkg::Q_ONE);
  localparam longint P_SCALE    = longint'(1) << pidaw_pkg::GAIN_FRAC_W;
  localparam longint I_SCALE    = longint'(1) << pidaw_pkg::I_SHIFT;

  class pid_drive_model;
    longint kp, ki, kd, step, sp;
    longint integ, prev_meas;
    logic signed [OW-1:0] drive_expected[$];
    int errors;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      step = longint'(pidaw_pkg::TIME_STEP_RESET);
      sp = 0;
      integ = 0;
      prev_meas = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [XW-1:0] idx, logic [DW-1:0] data);
      case (idx)
        pidaw_pkg::REG_GAIN_PROP:  kp = longint'($signed(data));
        pidaw_pkg::REG_GAIN_INTEG: ki = longint'($signed(data));
        pidaw_pkg::REG_GAIN_DERIV: kd = longint'($signed(data));
        pidaw_pkg::REG_TIME_STEP:  step = longint'(data);
        pidaw_pkg::REG_SETPOINT:   sp = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function void accept_sample(pidaw_pkg::op_e op, logic signed [DW-1:0] meas);
      longint x, err, dx, dt, p_part, d_part, term, acc;
      if (op == pidaw_pkg::OP_CLEAR) begin
        integ = 0;
        return;
      end
      x = meas;
      dt = (step == 0) ? 1 : step;
      err = sp - x;
      dx = x - prev_meas;
      p_part = (kp * err) / P_SCALE;
      d_part = (kd * dx * P_SCALE) / dt;
      term = p_part - d_part;
      if (term > Q_ONE) term = Q_ONE;
      if (term < -Q_ONE) term = -Q_ONE;
      acc = integ + (ki * err * dt) / I_SCALE;
      if (term + acc > Q_ONE) begin
        acc = Q_ONE - term;
      end else if (term + acc < -Q_ONE) begin
        acc = -Q_ONE - term;
      end
      integ = acc;
      prev_meas = x;
      drive_expected.push_back(OW'(term + acc));
    endfunction

    function void check_drive(logic signed [OW-1:0] drive);
      logic signed [OW-1:0] want;
      if (drive_expected.size() == 0) begin
        errors++;
        $display("%0t unexpected drive word: expected none, actual %0d", $time, drive);
      end else begin
        want = drive_expected.pop_front();
        if (want !== drive) begin
          errors++;
          $display("%0t drive mismatch: expected %0d, actual %0d", $time, want, drive);
        end
      end
    endfunction

    function int pending();
      return drive_expected.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycle_count = 0;
  int   src_idle_pct;
  int   snk_idle_pct;
  logic signed [DW-1:0] last_meas;
  logic signed [DW-1:0] cur_setpoint;

  pid_drive_model ctrl_pred = new();

  pidaw_cfg_if    cfg_bus ();
  pidaw_sample_if sample_bus ();
  pidaw_drive_if  drive_bus ();

  pid_antiwindup_controller_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (sample_bus),
    .drive_o  (drive_bus)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    drive_bus.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && drive_bus.valid && drive_bus.ready) begin
      ctrl_pred.check_drive(drive_bus.drive);
    end
  end

  task automatic write_cfg(logic [XW-1:0] idx, logic [DW-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    ctrl_pred.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    sample_bus.valid = 1'b0;
    while (ctrl_pred.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_regs(logic [DW-1:0] kp, logic [DW-1:0] ki,
                              logic [DW-1:0] kd, logic [DW-1:0] step,
                              logic [DW-1:0] sp);
    wait_drained();
    write_cfg(pidaw_pkg::REG_GAIN_PROP, kp);
    write_cfg(pidaw_pkg::REG_GAIN_INTEG, ki);
    write_cfg(pidaw_pkg::REG_GAIN_DERIV, kd);
    write_cfg(pidaw_pkg::REG_TIME_STEP, step);
    write_cfg(pidaw_pkg::REG_SETPOINT, sp);
    cfg_bus.valid = 1'b0;
    cur_setpoint = sp;
  endtask

  task automatic send_word(pidaw_pkg::op_e op, logic signed [DW-1:0] meas);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    if ($urandom_range(99) < src_idle_pct) begin
      sample_bus.valid = 1'b0;
      repeat ($urandom_range(1, 90)) @(negedge clk_i);
    end
    sample_bus.valid       = 1'b1;
    sample_bus.operation   = op;
    sample_bus.measurement = meas;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    ctrl_pred.accept_sample(op, meas);
    if (op == pidaw_pkg::OP_SAMPLE) last_meas = meas;
    @(negedge clk_i);
  endtask

  function automatic logic [DW-1:0] rand_gain();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return DW'(int'($urandom_range(0, 1536)) - 768);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic send_random_word();
    int pick;
    int span;
    int v;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_word(pidaw_pkg::OP_CLEAR, DW'($urandom));
    end else if (pick < 13) begin
      send_word(pidaw_pkg::OP_SAMPLE, $urandom_range(1) ? 16'sh7FFF : 16'sh8000);
    end else if (pick < 38) begin
      send_word(pidaw_pkg::OP_SAMPLE, DW'($urandom));
    end else begin
      span = 1 << $urandom_range(1, 10);
      v = ($urandom_range(3) == 0) ? int'(cur_setpoint) : int'(last_meas);
      v = v + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_word(pidaw_pkg::OP_SAMPLE, DW'(v));
    end
  endtask

  initial begin
    logic [DW-1:0] step;
    logic [DW-1:0] sp;
    rst_ni                 = 1'b0;
    src_idle_pct           = 0;
    snk_idle_pct           = 0;
    last_meas              = '0;
    cur_setpoint           = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
    sample_bus.valid       = 1'b0;
    sample_bus.operation   = pidaw_pkg::OP_SAMPLE;
    sample_bus.measurement = '0;
    drive_bus.ready        = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: all gains zero give a zero drive.
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh7FFF);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh8000);

    program_regs(16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h7FFF);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh8000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh8000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh7FFF);
    send_word(pidaw_pkg::OP_CLEAR, 16'sh0000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh0000);

    program_regs(16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'h8000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh7FFF);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh8000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh0000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sh7FFF);

    // A zero time step must behave as a step of one.
    program_regs(16'h0100, 16'h0100, 16'h7FFF, 16'h0000, 16'h0000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sd100);
    send_word(pidaw_pkg::OP_SAMPLE, -16'sd100);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sd4096);
    send_word(pidaw_pkg::OP_CLEAR, 16'shFFFF);
    send_word(pidaw_pkg::OP_SAMPLE, -16'sd4096);

    // Writes to indexes past the last register must leave the settings alone.
    program_regs(16'h0100, 16'h1000, 16'hFF00, pidaw_pkg::TIME_STEP_RESET, 16'd1000);
    write_cfg(XW'(pidaw_pkg::REG_SETPOINT) + 3'd1, 16'hFFFF);
    write_cfg(XW'(pidaw_pkg::REG_SETPOINT) + 3'd2, 16'h5A5A);
    write_cfg(XW'(pidaw_pkg::REG_SETPOINT) + 3'd3, 16'h0000);
    cfg_bus.valid = 1'b0;
    send_word(pidaw_pkg::OP_SAMPLE, 16'sd0);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sd1000);
    send_word(pidaw_pkg::OP_SAMPLE, 16'sd2000);

    for (int g = 0; g < RAND_GROUPS; g++) begin
      case ($urandom_range(4))
        0: step = 16'h0001;
        1: step = 16'hFFFF;
        2: step = DW'($urandom_range(1, 65535));
        default: step = DW'($urandom_range(100, 2000));
      endcase
      sp = $urandom_range(1) ? DW'($urandom) : DW'(int'($urandom_range(0, 8192)) - 4096);
      program_regs(rand_gain(), rand_gain(), rand_gain(), step, sp);
      if (g < RAND_GROUPS / 3) begin
        src_idle_pct = 10;
        snk_idle_pct = 55;
      end else if (g < 2 * RAND_GROUPS / 3) begin
        src_idle_pct = 55;
        snk_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      for (int n = 0; n < GROUP_WORDS; n++) begin
        send_random_word();
      end
    end

    wait_drained();
    if (ctrl_pred.pending() != 0) begin
      $display("%0t drive words missing: expected %0d more, actual 0",
               $time, ctrl_pred.pending());
    end
    if (ctrl_pred.errors == 0 && ctrl_pred.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
